FILE: rtl/fpva_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpva_pkg
// Shared types, codes and binary16 helper functions for the vector ALU.
// ---------------------------------------------------------------------------
package fpva_pkg;

  localparam int unsigned DefLanes = 16;
  localparam int unsigned InLanes  = 16;
  localparam int unsigned HW       = 16;

  localparam logic [15:0] QNAN16 = 16'h7E00;

  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_SUB    = 3'd1,
    REQ_MAX    = 3'd2,
    REQ_RSUM   = 3'd3,
    REQ_RMAX   = 3'd4,
    REQ_ZERO   = 3'd5,
    REQ_NOP6   = 3'd6,
    REQ_NOP7   = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request and burst
    logic step;     // process one lane
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;     // current lane is the last one
  } sts_t;

  function automatic logic h_is_nan(input logic [15:0] h);
    return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
  endfunction

  function automatic logic h_is_inf(input logic [15:0] h);
    return h[14:0] == 15'h7C00;
  endfunction

  // ordered compare, nan gives false, zeros equal
  function automatic logic h_greater(input logic [15:0] a, input logic [15:0] b);
    logic signed [16:0] ka;
    logic signed [16:0] kb;
    ka = a[15] ? -$signed({2'b00, a[14:0]}) : $signed({2'b00, a[14:0]});
    kb = b[15] ? -$signed({2'b00, b[14:0]}) : $signed({2'b00, b[14:0]});
    if (h_is_nan(a) || h_is_nan(b)) begin
      return 1'b0;
    end
    return ka > kb;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fpva_hadd.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpva_hadd
// Binary16 adder, round to nearest even, fixed-point align and normalize.
// ---------------------------------------------------------------------------
module fpva_hadd
  import fpva_pkg::*;
(
  input  wire logic [15:0] a,
  input  wire logic [15:0] b,
  output logic      [15:0] y
);

  logic [4:0]  ea, eb, ebig, d;
  logic [10:0] ma, mb;
  logic [13:0] xa, xb;      // mantissa with 3 guard bits
  logic [13:0] big, sml, smls;
  logic        sb, ss, sticky, sub;
  logic [14:0] sum;
  logic [3:0]  lz;
  logic [5:0]  e;
  logic [14:0] nrm;
  logic [10:0] q;
  logic        rnd;
  logic [11:0] qr;
  logic [5:0]  er;
  logic [15:0] bits;
  logic        swap;

  always_comb begin
    ea = (a[14:10] == 5'd0) ? 5'd1 : a[14:10];
    eb = (b[14:10] == 5'd0) ? 5'd1 : b[14:10];
    ma = {a[14:10] != 5'd0, a[9:0]};
    mb = {b[14:10] != 5'd0, b[9:0]};
    xa = {ma, 3'b000};
    xb = {mb, 3'b000};
    swap = ({eb, mb} > {ea, ma});
    big  = swap ? xb : xa;
    sml  = swap ? xa : xb;
    sb   = swap ? b[15] : a[15];
    ss   = swap ? a[15] : b[15];
    ebig = swap ? eb : ea;
    d    = swap ? (eb - ea) : (ea - eb);
    // align with sticky
    if (d >= 5'd14) begin
      smls = 14'd0;
      sticky = (sml != 14'd0);
    end else begin
      smls = sml >> d;
      sticky = ((sml & ((14'd1 << d) - 14'd1)) != 14'd0);
    end
    smls[0] = smls[0] | sticky;
    sub = sb ^ ss;
    sum = sub ? ({1'b0, big} - {1'b0, smls}) : ({1'b0, big} + {1'b0, smls});
    // leading one search
    lz = 4'd0;
    for (int i = 0; i < 15; i++) begin
      if (sum[i]) lz = 4'(14 - i);
    end
    // normalize: target leading one at bit 13
    e = {1'b0, ebig} + 6'd1;
    nrm = sum;
    if (sum[14]) begin
      nrm = {1'b0, sum[14:2], sum[1] | sum[0]};
    end else begin
      // shift left by lz-1 but not below exponent 1
      if ({2'b00, lz} - 6'd1 >= e - 6'd1) begin
        nrm = sum << (e - 6'd2);
        e = 6'd1;
      end else begin
        nrm = sum << (lz - 4'd1);
        e = e - {2'b00, lz};
      end
    end
    // nrm[13:3] mantissa, [2] guard, [1:0] round/sticky
    q   = nrm[13:3];
    rnd = nrm[2] && ((nrm[1:0] != 2'b00) || nrm[3]);
    qr  = {1'b0, q} + {11'd0, rnd};
    er  = e;
    if (qr[11]) begin
      qr = qr >> 1;
      er = er + 6'd1;
    end
    if (er >= 6'd31) begin
      bits = {sb, 15'h7C00};
    end else if (!qr[10]) begin
      bits = {sb, 5'd0, qr[9:0]};
    end else begin
      bits = {sb, er[4:0], qr[9:0]};
    end
    if (sum == 15'd0) begin
      bits = {a[15] & b[15], 15'd0};
    end
    if (h_is_nan(a) || h_is_nan(b)) begin
      y = QNAN16;
    end else if (h_is_inf(a) && h_is_inf(b)) begin
      y = (a[15] ^ b[15]) ? QNAN16 : a;
    end else if (h_is_inf(a)) begin
      y = a;
    end else if (h_is_inf(b)) begin
      y = b;
    end else begin
      y = bits;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/fpva_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpva_ctrl
// Controller: sequences the lanes through the shared datapath.
// ---------------------------------------------------------------------------
module fpva_ctrl
  import fpva_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_RUN;
      ST_RUN:  if (sts.last) state_next = ST_OUT;
      ST_OUT:  if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // outputs
  always_comb begin
    in_stall   = (state != ST_IDLE);
    out_valid  = (state == ST_OUT);
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.step   = (state == ST_RUN);
  end

endmodule

`default_nettype wire

FILE: rtl/fpva_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpva_dp
// Datapath: vector and scalar registers, lane counter, shared fp16 adder.
// ---------------------------------------------------------------------------
module fpva_dp
  import fpva_pkg::*;
#(
  parameter int unsigned LANES = DefLanes
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  input  wire logic [2:0]            req_type,
  input  wire logic [InLanes*HW-1:0] burst,
  output logic      [InLanes*HW-1:0] vec_out,
  output logic      [HW-1:0]         scalar_out
);

  localparam int unsigned CW = (LANES > 1) ? $clog2(LANES) : 1;

  logic [HW-1:0]         vlane [LANES];
  logic [HW-1:0]         scalar_reg;
  logic [InLanes*HW-1:0] bur;
  req_t                  req;
  logic [CW-1:0]         cnt;
  logic [HW-1:0]         cur, bl, add_a, add_b, add_y;

  // current lane and its burst lane
  always_comb begin
    cur = vlane[cnt];
    bl  = '0;
    for (int i = 0; i < InLanes; i++) begin
      if (32'(cnt) == i) bl = bur[i*HW +: HW];
    end
    sts.last = (32'(cnt) == LANES - 1);
    if (req == REQ_RSUM) begin
      add_a = scalar_reg;
      add_b = cur;
    end else begin
      add_a = cur;
      add_b = (req == REQ_SUB) ? {~bl[15], bl[14:0]} : bl;
    end
  end

  fpva_hadd u_add (.a(add_a), .b(add_b), .y(add_y));

  // request capture and lane counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.step) begin
      cnt <= sts.last ? '0 : cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_t'(req_type);
      bur <= burst;
    end
  end

  // per-lane update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) vlane[i] <= '0;
      scalar_reg <= '0;
    end else if (cmd.step) begin
      unique case (req)
        REQ_ADD, REQ_SUB: vlane[cnt] <= add_y;
        REQ_MAX:  if (!h_greater(cur, bl)) vlane[cnt] <= bl;
        REQ_RSUM: scalar_reg <= add_y;
        REQ_RMAX: if (h_greater(cur, scalar_reg)) scalar_reg <= cur;
        REQ_ZERO: scalar_reg <= '0;
        default: ;
      endcase
    end
  end

  // result packing
  always_comb begin
    vec_out = '0;
    for (int i = 0; i < InLanes; i++) begin
      if (i < LANES) vec_out[i*HW +: HW] = vlane[i];
    end
    scalar_out = scalar_reg;
  end

endmodule

`default_nettype wire

FILE: rtl/fp16_vector_accumulate_reduce_alu_unit.sv
`default_nettype none
// Flow: a request is captured on accept, then the lanes are stepped in order
// and out_valid rises; in_stall holds off a new request until the result is taken.
// A single shared fp16 adder visits one lane per cycle, and the result register holds until taken.
// Reset: rst synchronous active high, clears all lanes and the scalar to +0.
// ---------------------------------------------------------------------------
// fp16_vector_accumulate_reduce_alu_unit
// Binary16 vector accumulator with reduce-sum and reduce-max into a scalar.
// ---------------------------------------------------------------------------
module fp16_vector_accumulate_reduce_alu_unit
  import fpva_pkg::*;
#(
  parameter int unsigned LANES = DefLanes
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [63:0] burst_lanes_0_3,
  input  wire logic [63:0] burst_lanes_4_7,
  input  wire logic [63:0] burst_lanes_8_11,
  input  wire logic [63:0] burst_lanes_12_15,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      vec_lanes_0_3,
  output logic [63:0]      vec_lanes_4_7,
  output logic [63:0]      vec_lanes_8_11,
  output logic [63:0]      vec_lanes_12_15,
  output logic [15:0]      scalar_value
);

  cmd_t                  cmd;
  sts_t                  sts;
  logic [InLanes*HW-1:0] vec;

  fpva_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  fpva_dp #(.LANES(LANES)) u_dp (
    .clk, .rst, .cmd, .sts, .req_type,
    .burst({burst_lanes_12_15, burst_lanes_8_11, burst_lanes_4_7, burst_lanes_0_3}),
    .vec_out(vec), .scalar_out(scalar_value)
  );

  // unpack result lanes
  assign vec_lanes_0_3   = vec[63:0];
  assign vec_lanes_4_7   = vec[127:64];
  assign vec_lanes_8_11  = vec[191:128];
  assign vec_lanes_12_15 = vec[255:192];

endmodule

`default_nettype wire
